>>> rtl/core/rgbds_pkg.sv
// rgbds_pkg: types, constants and channel arithmetic for the 2x2 box downscaler.
// Used by rgb_box_downscale_2x2_core; depends on nothing.
`timescale 1ns / 1ps

package rgbds_pkg;

   // geometry
   localparam int DIM_W             = 13;
   localparam int DEF_MAX_SRC_WIDTH = 4096;
   localparam int PAIR_SUM_W        = 27;

   // register reset values
   localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 13'd480;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 1'd1;

   typedef struct packed {
      logic [31:0] in_pixel;
      logic        frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [23:0] out_pixel;
      logic        line_end;
      logic        frame_end;
   } rsp_payload_type;

   // three 9-bit channel sums of two pixels, red high
   function automatic logic [PAIR_SUM_W-1:0] pair_sum(input logic [23:0] a,
                                                      input logic [23:0] b);
      logic [8:0] r;
      logic [8:0] g;
      logic [8:0] bl;
      r  = {1'b0, a[23:16]} + {1'b0, b[23:16]};
      g  = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
      bl = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
      return {r, g, bl};
   endfunction

   // rounded mean of one channel from two pair sums
   function automatic logic [7:0] mean_channel(input logic [8:0] s1, input logic [8:0] s2);
      logic [9:0] t;
      t = {1'b0, s1} + {1'b0, s2} + 10'd2;
      return t[9:2];
   endfunction

   function automatic logic [23:0] mean_pixel(input logic [PAIR_SUM_W-1:0] s1,
                                              input logic [PAIR_SUM_W-1:0] s2);
      return {mean_channel(s1[26:18], s2[26:18]),
              mean_channel(s1[17:9],  s2[17:9]),
              mean_channel(s1[8:0],   s2[8:0])};
   endfunction

endpackage

>>> rtl/core/rgb_box_downscale_2x2_core.sv
// rgb_box_downscale_2x2_core: halves an XRGB raster stream in both directions.
// Depends on rgbds_pkg for payload types, register codes and channel arithmetic.
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   rgbds_pkg::req_payload_type
// rsp      out        rsp_valid/rsp_stall   rgbds_pkg::rsp_payload_type
// csr      in         csr_valid/csr_ready   csr_index, csr_data (13 bits)
//
// One source pixel per clock while the output does not stall; a result passes the middle
// stage and the output register after the odd-column, odd-row pixel that completes its
// 2x2 block. The line memory is written and read only at input transfer, one access per
// cycle, in order. Reset is synchronous; the line memory is not cleared. A stalled result
// is held in the output register; the input stalls only when both it and the middle
// stage are full.
module rgb_box_downscale_2x2_core #(
   parameter int MAX_SRC_WIDTH = rgbds_pkg::DEF_MAX_SRC_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rgbds_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rgbds_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rgbds_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rgbds_pkg::DIM_W-1:0]           csr_data
);

   localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int DW         = rgbds_pkg::DIM_W;
   localparam int SW         = rgbds_pkg::PAIR_SUM_W;

   // configuration registers
   logic [DW-1:0] src_width_ff;
   logic [DW-1:0] src_height_ff;

   // frame position and left half of the current pair
   logic [DW-1:0] column_count_ff;
   logic [DW-1:0] row_count_ff;
   logic [DW-1:0] column_count_in;
   logic [DW-1:0] row_count_in;
   logic [23:0]   left_pixel_ff;

   // line memory of pair sums
   logic [SW-1:0] line_mem [LINE_DEPTH];
   logic [SW-1:0] rd_sum_ff;

   // middle stage
   logic          s1_valid_ff;
   logic [SW-1:0] s1_sum_ff;
   logic          s1_le_ff;
   logic          s1_fe_ff;

   // output register
   logic                       rsp_valid_ff;
   rgbds_pkg::rsp_payload_type rsp_payload_ff;

   // front-end decode
   logic              accept;
   logic              s1_advance;
   logic [DW-1:0]     col;
   logic [DW-1:0]     row;
   logic [DW-2:0]     idx;
   logic [DW-1:0]     line_len;
   logic [DW-1:0]     frame_len;
   logic [DW-1:0]     eff_w;
   logic [DW-1:0]     out_w;
   logic [DW-1:0]     out_h;
   logic              pair_ok;
   logic              mem_we;
   logic              mem_re;
   logic              emit;
   logic              le;
   logic              fe;
   logic [ADDR_W-1:0] addr;
   logic [SW-1:0]     cur_sum;

   // handshake
   always_comb begin
      s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall  = s1_valid_ff && !s1_advance;
      accept     = req_valid && !req_stall;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // decode position and decide write, read and emit
   always_comb begin
      col       = req_payload.frame_start ? '0 : column_count_ff;
      row       = req_payload.frame_start ? '0 : row_count_ff;
      idx       = col[DW-1:1];
      line_len  = (src_width_ff == '0)  ? DW'(1) : src_width_ff;
      frame_len = (src_height_ff == '0) ? DW'(1) : src_height_ff;
      eff_w     = (32'(src_width_ff) < MAX_SRC_WIDTH) ? src_width_ff : DW'(MAX_SRC_WIDTH);
      out_w     = eff_w >> 1;
      out_h     = src_height_ff >> 1;
      pair_ok   = col[0] && ({1'b0, idx} < out_w) && (32'(idx) < LINE_DEPTH);
      mem_we    = accept && pair_ok && !row[0];
      emit      = pair_ok && row[0] && ((row >> 1) < out_h);
      mem_re    = accept && emit;
      le        = ({1'b0, idx} == out_w - DW'(1));
      fe        = le && ((row >> 1) == out_h - DW'(1));
      addr      = ADDR_W'(idx);
      cur_sum   = rgbds_pkg::pair_sum(left_pixel_ff, req_payload.in_pixel[23:0]);
   end

   // advance counters, wrapping at line and frame end
   always_comb begin
      if ({1'b0, col} + (DW+1)'(1) >= {1'b0, line_len}) begin
         column_count_in = '0;
         row_count_in    = ({1'b0, row} + (DW+1)'(1) >= {1'b0, frame_len}) ?
                           '0 : row + DW'(1);
      end else begin
         column_count_in = col + DW'(1);
         row_count_in    = row;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= rgbds_pkg::SRC_WIDTH_RST;
         src_height_ff <= rgbds_pkg::SRC_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rgbds_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            rgbds_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // position counters and left pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_pixel_ff   <= '0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         if (!col[0]) begin
            left_pixel_ff <= req_payload.in_pixel[23:0];
         end
      end
   end

   // line memory: store pair sums on even rows, fetch them on odd rows
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[addr] <= cur_sum;
      end
      if (mem_re) begin
         rd_sum_ff <= line_mem[addr];
      end
   end

   // middle stage: hold current pair sum and line flags while the read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= emit;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_sum_ff <= cur_sum;
         s1_le_ff  <= le;
         s1_fe_ff  <= fe;
      end
   end

   // output register: average the two pair sums and hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_payload_ff.out_pixel <= rgbds_pkg::mean_pixel(rd_sum_ff, s1_sum_ff);
         rsp_payload_ff.line_end  <= s1_le_ff;
         rsp_payload_ff.frame_end <= s1_fe_ff;
      end
   end

endmodule

>>> tb/tb.sv
// tb: self-checking bench for rgb_box_downscale_2x2_core, the 2x2 box downscaler.
// Drives pixels, register writes and output stalls; checks each averaged pixel
// against directed expectations or a cycle-free model of the scaler. Depends on rgbds_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int RESET_CYCLES   = 2;
   localparam int DRAIN_CYCLES   = 8;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int QUIET_AFTER    = 1250;
   localparam int MAX_RANDOM_W   = 24;
   localparam int MAX_W          = rgbds_pkg::DEF_MAX_SRC_WIDTH;
   localparam int LINE_DEPTH     = rgbds_pkg::DEF_MAX_SRC_WIDTH / 2;
   localparam int MAX_PRINTS     = 100;

   // directed plan: pixel transfers and register writes
   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_WIDTH,
      ROW_HEIGHT
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic                       fs;
      logic [31:0]                data;
      logic                       typed;
      rgbds_pkg::rsp_payload_type want;
   } plan_row_type;

   localparam int PLAN_LEN = 31;

   plan_row_type directed_plan [PLAN_LEN] = '{
      // 4x2 frame: full-scale block, then black block with top byte set
      '{ROW_WIDTH,  1'b0, 32'd4,         1'b0, '0},
      '{ROW_HEIGHT, 1'b0, 32'd2,         1'b0, '0},
      '{ROW_PIXEL,  1'b1, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF00_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h0000_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFFFF_FFFF, 1'b1, '{24'hFF_FFFF, 1'b0, 1'b0}},
      '{ROW_PIXEL,  1'b0, 32'h0000_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF00_0000, 1'b1, '{24'h00_0000, 1'b1, 1'b1}},
      // second frame by wrap alone: rounding up and down, then a 3+3+3+3 block
      '{ROW_PIXEL,  1'b0, 32'h0001_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h0001_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF03_0303, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF03_0303, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h0001_0000, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h0000_0102, 1'b1, '{24'h01_0001, 1'b0, 1'b0}},
      '{ROW_PIXEL,  1'b0, 32'hFF03_0303, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF03_0303, 1'b1, '{24'h03_0303, 1'b1, 1'b1}},
      // 3x3 frame: odd column and row dropped, restart in the middle of a line
      '{ROW_WIDTH,  1'b0, 32'd3,         1'b0, '0},
      '{ROW_HEIGHT, 1'b0, 32'd3,         1'b0, '0},
      '{ROW_PIXEL,  1'b1, 32'h1234_5678, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h9ABC_DEF0, 1'b0, '0},
      '{ROW_PIXEL,  1'b1, 32'h0F0F_0F0F, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hF0F0_F0F0, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h8080_8080, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h7F7F_7F7F, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h0101_0101, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h5555_5555, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'h00FF_00FF, 1'b0, '0},
      '{ROW_PIXEL,  1'b0, 32'hFF00_FF00, 1'b0, '0}
   };

   logic                                    clock       = 1'b0;
   logic                                    reset       = 1'b1;
   logic                                    req_valid   = 1'b0;
   logic                                    req_stall;
   rgbds_pkg::req_payload_type              req_payload = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall   = 1'b0;
   rgbds_pkg::rsp_payload_type              rsp_payload;
   logic                                    csr_valid   = 1'b0;
   logic                                    csr_ready;
   logic [rgbds_pkg::CSR_INDEX_W-1:0]       csr_index   = '0;
   logic [rgbds_pkg::DIM_W-1:0]             csr_data    = '0;

   // typed expectation that travels with the current pixel
   logic                                    row_typed   = 1'b0;
   rgbds_pkg::rsp_payload_type              row_want    = '0;

   // scaler model state
   logic [rgbds_pkg::PAIR_SUM_W-1:0]        line_sums [LINE_DEPTH];
   logic [23:0]                             held_left   = '0;
   logic [rgbds_pkg::DIM_W-1:0]             col_q       = '0;
   logic [rgbds_pkg::DIM_W-1:0]             row_q       = '0;
   logic [rgbds_pkg::DIM_W-1:0]             width_q     = rgbds_pkg::SRC_WIDTH_RST;
   logic [rgbds_pkg::DIM_W-1:0]             height_q    = rgbds_pkg::SRC_HEIGHT_RST;

   rgbds_pkg::rsp_payload_type              block_means_q [$];
   int unsigned                             mismatch_count = 0;
   int unsigned                             random_items   = 0;
   int unsigned                             idle_cycles    = 0;
   int unsigned                             gap_pct        = 0;
   int unsigned                             stall_pct      = 0;
   int unsigned                             stall_left     = 0;

   rgb_box_downscale_2x2_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // advance the scaler model by one source pixel; return 1 when a block completes
   function automatic bit scale_pixel(input rgbds_pkg::req_payload_type req,
                                      output rgbds_pkg::rsp_payload_type mean_px);
      logic [23:0]                      pix;
      logic [rgbds_pkg::PAIR_SUM_W-1:0] pair;
      logic [rgbds_pkg::PAIR_SUM_W-1:0] prev;
      int unsigned                      line_len;
      int unsigned                      frame_len;
      int unsigned                      eff_w;
      int unsigned                      out_w;
      int unsigned                      out_h;
      int unsigned                      col;
      int unsigned                      row;
      int unsigned                      idx;
      bit                               hit;
      pix       = req.in_pixel[23:0];
      line_len  = (width_q == '0) ? 1 : int'(width_q);
      frame_len = (height_q == '0) ? 1 : int'(height_q);
      eff_w     = (int'(width_q) < MAX_W) ? int'(width_q) : MAX_W;
      out_w     = eff_w >> 1;
      out_h     = int'(height_q) >> 1;
      hit       = 1'b0;
      mean_px   = '0;
      if (req.frame_start) begin
         col_q = '0;
         row_q = '0;
      end
      col = col_q;
      row = row_q;
      idx = col >> 1;
      if (col % 2 == 0) begin
         held_left = pix;
      end else if (idx < out_w && idx < LINE_DEPTH) begin
         // horizontal sums per channel, 9 bits each, red high
         for (int ch = 0; ch < 3; ch++) begin
            pair[ch*9 +: 9] = {1'b0, held_left[ch*8 +: 8]} + {1'b0, pix[ch*8 +: 8]};
         end
         if (row % 2 == 0) begin
            line_sums[idx] = pair;
         end else if ((row >> 1) < out_h) begin
            prev = line_sums[idx];
            for (int ch = 0; ch < 3; ch++) begin
               mean_px.out_pixel[ch*8 +: 8] =
                  8'(({1'b0, prev[ch*9 +: 9]} + {1'b0, pair[ch*9 +: 9]} + 10'd2) >> 2);
            end
            mean_px.line_end  = (idx == out_w - 1);
            mean_px.frame_end = mean_px.line_end && ((row >> 1) == out_h - 1);
            hit = 1'b1;
         end
      end
      // wrap the column at the line length, the row at the frame length
      if (col + 1 >= line_len) begin
         col_q = '0;
         row_q = (row + 1 >= frame_len) ? '0 : rgbds_pkg::DIM_W'(row + 1);
      end else begin
         col_q = rgbds_pkg::DIM_W'(col + 1);
      end
      return hit;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // hold the input low until every expected pixel is out and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (block_means_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rgbds_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rgbds_pkg::DIM_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == rgbds_pkg::CSR_SRC_WIDTH) width_q = value;
      else height_q = value;
   endtask

   // present one pixel, with an optional idle burst first, and wait for its transfer
   task automatic send_pixel(input logic fs, input logic [31:0] pix,
                             input logic typed, input rgbds_pkg::rsp_payload_type want);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_pixel: pix, frame_start: fs};
      row_typed   <= typed;
      row_want    <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] random_pixel();
      logic [31:0] p;
      p = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         for (int ch = 0; ch < 4; ch++) p[ch*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return p;
   endfunction

   // one whole frame of random pixels at a fixed geometry
   task automatic run_large_phase(input int unsigned w, input int unsigned h);
      write_csr(rgbds_pkg::CSR_SRC_WIDTH, rgbds_pkg::DIM_W'(w));
      write_csr(rgbds_pkg::CSR_SRC_HEIGHT, rgbds_pkg::DIM_W'(h));
      for (int k = 0; k < w * h; k++) send_pixel(k == 0, random_pixel(), 1'b0, '0);
   endtask

   // random geometry, mostly whole frames, with stray frame starts as noise
   task automatic run_random_phase();
      int unsigned wi;
      int unsigned hi;
      int unsigned frame_len;
      int unsigned count;
      int unsigned pick;
      logic        fs;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         wi = $urandom_range(2, MAX_RANDOM_W);
         hi = $urandom_range(2, 8);
      end else if (pick == 7) begin
         wi = $urandom_range(0, 1);
         hi = $urandom_range(0, 8191);
      end else if (pick == 8) begin
         wi = $urandom_range(2, MAX_RANDOM_W);
         hi = $urandom_range(0, 1);
      end else begin
         wi = $urandom_range(0, 8191);
         hi = 0;
      end
      frame_len = ((wi == 0) ? 1 : wi) * ((hi == 0) ? 1 : hi);
      count = frame_len * $urandom_range(1, 3);
      if (count > 300) count = $urandom_range(20, 300);
      if (random_items >= QUIET_AFTER) begin
         gap_pct   = 0;
         stall_pct = 0;
      end else begin
         gap_pct   = $urandom_range(0, 3) * 20;
         stall_pct = $urandom_range(0, 3) * 20;
      end
      write_csr(rgbds_pkg::CSR_SRC_WIDTH, rgbds_pkg::DIM_W'(wi));
      write_csr(rgbds_pkg::CSR_SRC_HEIGHT, rgbds_pkg::DIM_W'(hi));
      // skipping the first frame start keeps counters from the old geometry
      for (int k = 0; k < count; k++) begin
         if (k == 0) fs = ($urandom_range(0, 3) != 0);
         else if (k % frame_len == 0) fs = $urandom_range(0, 1);
         else fs = ($urandom_range(0, 49) == 0);
         send_pixel(fs, random_pixel(), 1'b0, '0);
      end
      random_items += count;
   endtask

   // record the expected pixel on every input transfer
   always @(posedge clock) begin : accept_pixel
      rgbds_pkg::rsp_payload_type mean_px;
      bit                         hit;
      if (!reset && req_valid && !req_stall) begin
         hit = scale_pixel(req_payload, mean_px);
         if (row_typed) block_means_q.push_back(row_want);
         else if (hit) block_means_q.push_back(mean_px);
      end
   end

   // compare every output transfer with the oldest expected pixel
   always @(posedge clock) begin : check_result
      rgbds_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (block_means_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel %h", rsp_payload.out_pixel));
         end else begin
            want = block_means_q.pop_front();
            if (rsp_payload.out_pixel !== want.out_pixel)
               flag_mismatch($sformatf("out_pixel %h, want %h",
                                       rsp_payload.out_pixel, want.out_pixel));
            if (rsp_payload.line_end !== want.line_end)
               flag_mismatch($sformatf("line_end %b, want %b",
                                       rsp_payload.line_end, want.line_end));
            if (rsp_payload.frame_end !== want.frame_end)
               flag_mismatch($sformatf("frame_end %b, want %b",
                                       rsp_payload.frame_end, want.frame_end));
         end
      end
   end

   // stall the output in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
         stall_left = $urandom_range(1, 10);
      rsp_stall <= (stall_left > 0);
   end

   // count cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("** rgb_box_downscale_2x2_core: FAILED **");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed plan
      gap_pct   = 30;
      stall_pct = 30;
      for (int i = 0; i < PLAN_LEN; i++) begin
         case (directed_plan[i].kind)
            ROW_WIDTH: begin
               write_csr(rgbds_pkg::CSR_SRC_WIDTH, directed_plan[i].data[rgbds_pkg::DIM_W-1:0]);
            end
            ROW_HEIGHT: begin
               write_csr(rgbds_pkg::CSR_SRC_HEIGHT, directed_plan[i].data[rgbds_pkg::DIM_W-1:0]);
            end
            default: begin
               send_pixel(directed_plan[i].fs, directed_plan[i].data,
                          directed_plan[i].typed, directed_plan[i].want);
            end
         endcase
      end

      // fill every line entry that the random geometries can read back
      gap_pct   = 10;
      stall_pct = 10;
      run_large_phase(MAX_RANDOM_W, 2);

      while (random_items < RANDOM_ITEMS) run_random_phase();

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (block_means_q.size() != 0)
         flag_mismatch($sformatf("%0d pixels never came out", block_means_q.size()));
      if (mismatch_count == 0) begin
         $display("** rgb_box_downscale_2x2_core: PASSED **");
      end else begin
         $display("** rgb_box_downscale_2x2_core: FAILED **");
      end
      $finish;
   end

endmodule
